// File: design/pdf_pkg.sv
package pdf_pkg;

    localparam int IDENT_W          = 16;
    localparam int ADDR_W           = 32;
    localparam int KEY_W            = IDENT_W + ADDR_W;
    localparam int CAPACITY_DEFAULT = 256;

    typedef logic [IDENT_W-1:0] ident_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [KEY_W-1:0]   key_t;

    // Join identification (upper) and source address (lower) into one key
    function automatic key_t make_key(input ident_t id, input addr_t addr);
        make_key = {id, addr};
    endfunction

endpackage

// File: design/pdf_cam.sv
module pdf_cam #(
    parameter int CAPACITY = pdf_pkg::CAPACITY_DEFAULT,
    parameter int SLOT_W   = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pdf_pkg::key_t       search_key,
    output logic                hit,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_slot,
    input  pdf_pkg::key_t       wr_key
);
    import pdf_pkg::*;

    key_t                key_cell_reg [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] match;

    // Compare the search key against every cell in parallel
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = valid_reg[i] && (key_cell_reg[i] == search_key);
        end
    end

    assign hit = |match;

    // Write one cell; key cells hold no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (wr_en && (wr_slot == SLOT_W'(i)))
            begin
                key_cell_reg[i] <= wr_key;
            end
        end
    end

    // Set the valid mark of a written cell; clear all at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (wr_en && (wr_slot == SLOT_W'(i)))
                begin
                    valid_reg[i] <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/pdf_alloc.sv
module pdf_alloc #(
    parameter int CAPACITY = pdf_pkg::CAPACITY_DEFAULT,
    parameter int SLOT_W   = 8,
    parameter int COUNT_W  = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              alloc,
    output logic [SLOT_W-1:0] slot
);
    import pdf_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [SLOT_W-1:0]  oldest_reg;
    logic [SLOT_W-1:0]  oldest_next;
    logic               full;

    assign full = (count_reg == COUNT_W'(CAPACITY));

    // Fill slots in order until full, then overwrite the oldest
    assign slot = full ? oldest_reg : count_reg[SLOT_W-1:0];

    // Advance fill count or oldest pointer on each allocation
    always_comb
    begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        if (alloc)
        begin
            if (full)
            begin
                if (oldest_reg == SLOT_W'(CAPACITY - 1))
                begin
                    oldest_next = '0;
                end
                else
                begin
                    oldest_next = oldest_reg + SLOT_W'(1);
                end
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
        end
    end

endmodule

// File: design/packet_duplicate_filter_core.sv
// Channel  | Signals                                  | Handshake
// ---------+------------------------------------------+----------------------------
// input    | start, busy, ident, source_address        | item taken when start & !busy
// result   | done, is_duplicate                        | one-cycle strobe, no backpressure
//
// One item enters per cycle; busy stays low. The result strobe comes from the result
// register: the accepting edge loads the input register, which in turn loads the result
// register while a new nonzero key that misses is written into the ring of
// CAPACITY cells. The compare of the registered key against all cells and the ring
// write sit between those two registers. Reset clears all valid marks, the fill count
// and the oldest pointer at once; no clearing pass follows.
module packet_duplicate_filter_core #(
    parameter int CAPACITY = pdf_pkg::CAPACITY_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pdf_pkg::ident_t       ident,
    input  pdf_pkg::addr_t        source_address,
    output logic                  done,
    output logic                  is_duplicate
);
    import pdf_pkg::*;

    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic              accept;
    logic              in_valid_reg;
    logic              in_nonzero_reg;
    key_t              key_reg;
    logic              hit;
    logic              store;
    logic [SLOT_W-1:0] wr_slot;
    logic              done_reg;
    logic              dup_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capture the item key
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= make_key(ident, source_address);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_nonzero_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= accept;
            in_nonzero_reg <= accept && (ident != '0);
        end
    end

    pdf_cam #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .search_key (key_reg),
        .hit        (hit),
        .wr_en      (store),
        .wr_slot    (wr_slot),
        .wr_key     (key_reg)
    );

    // Remember a new nonzero key
    assign store = in_nonzero_reg && !hit;

    pdf_alloc #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W),
        .COUNT_W  (COUNT_W)
    ) u_alloc (
        .clk   (clk),
        .rst_n (rst_n),
        .alloc (store),
        .slot  (wr_slot)
    );

    // Register the result strobe and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            dup_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
            dup_reg  <= in_nonzero_reg && hit;
        end
    end

    assign done         = done_reg;
    assign is_duplicate = dup_reg;

endmodule

// File: design/pdf_checker.sv
module pdf_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input pdf_pkg::ident_t       ident,
    input pdf_pkg::addr_t        source_address,
    input logic                  done,
    input logic                  is_duplicate
);
    import pdf_pkg::*;

    // Every accepted item yields exactly one result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !done)
        else $error("result without an accepted item");

    // Zero identification is always forwarded
    a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (ident == '0)) |=> ##1 !is_duplicate)
        else $error("zero identification flagged as duplicate");

    // A nonzero key repeated in the next cycle is a duplicate
    a_repeat_dup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (ident != '0)
         ##1 (start && !busy && (ident == $past(ident))
              && (source_address == $past(source_address))))
        |=> ##1 is_duplicate)
        else $error("immediate repeat not flagged");

endmodule

bind packet_duplicate_filter_core pdf_checker u_pdf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .ident          (ident),
    .source_address (source_address),
    .done           (done),
    .is_duplicate   (is_duplicate)
);
